@@ hw/rtl/board_power_reset_supervisor_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef BOARD_POWER_RESET_SUPERVISOR_TOP_ASSERT_SVH
`define BOARD_POWER_RESET_SUPERVISOR_TOP_ASSERT_SVH

// Generic clocked assertion with an active-low reset.
`define BPRS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the default clock and reset names.
`define BPRS_ASSERT(lbl, prop, msg) \
  `BPRS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/bprs_pkg.sv @@
package bprs_pkg;

  localparam int unsigned TICK_MS_DEF = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USB_ON    = 3'd0,
    CFG_USB_OFF   = 3'd1,
    CFG_BAT_CUT   = 3'd2,
    CFG_KEY_TICKS = 3'd3,
    CFG_RST_HOLD  = 3'd4,
    CFG_UPS_HOLD  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CMD_RESTART    = 4'd0,
    CMD_LED        = 4'd1,
    CMD_WDCTRL     = 4'd2,
    CMD_WDKICK     = 4'd3,
    CMD_CURMAX     = 4'd4,
    CMD_CHARGE     = 4'd5,
    CMD_MODE       = 4'd6,
    CMD_WAKE_ALARM = 4'd7,
    CMD_OFF        = 4'd8,
    CMD_KEYTIME    = 4'd9
  } cmd_e;

  localparam logic [15:0] USB_ON_RST      = 16'd4500;
  localparam logic [15:0] USB_OFF_RST     = 16'd4000;
  localparam logic [15:0] BAT_CUT_RST     = 16'd3100;
  localparam logic [12:0] KEY_TICKS_RST   = 13'd100;
  localparam logic [7:0]  RST_HOLD_RST    = 8'd20;
  localparam logic [7:0]  UPS_HOLD_RST    = 8'd50;

  localparam logic [15:0] REBOOT_KEEP     = 16'hA600;
  localparam logic [15:0] REBOOT_USER     = 16'hA601;
  localparam logic [15:0] REBOOT_BOOTLDR  = 16'hA602;
  localparam logic [15:0] WD_KICK_KEY     = 16'h0042;
  localparam logic [15:0] CUR_MAX_MA      = 16'd200;
  localparam logic [15:0] KEYTIME_MIN_MS  = 16'd1000;
  localparam logic [15:0] KEYTIME_MAX_MS  = 16'd60000;
  localparam logic [12:0] KEY_TICKS_MAX   = 13'h1FFF;
  localparam logic [7:0]  SPI_RESET_TICKS = 8'd200;
  localparam logic [7:0]  SPI_WAKE_TICKS  = 8'd100;
  localparam logic [7:0]  CHARGE_LIM_RST  = 8'd70;
  localparam logic [3:0]  FLASH_PERIOD    = 4'd10;

  typedef struct packed {
    logic [15:0] usb_on;
    logic [15:0] usb_off;
    logic [15:0] bat_cut;
    logic [12:0] key_def;
    logic [7:0]  rst_hold;
    logic [7:0]  ups_hold;
  } cfg_t;

  typedef struct packed {
    logic        key_left;
    logic        key_right;
    logic        cmd_valid;
    logic [3:0]  cmd;
    logic [15:0] parameter_req;
    logic [15:0] input_voltage_mv;
    logic [15:0] battery_voltage_mv;
    logic        charging_active;
  } item_t;

  typedef struct packed {
    logic        arm_reset;
    logic        boot_normal;
    logic        led_on;
    logic        spi_enabled;
    logic        power_down;
    logic        full_charge_pulse;
    logic        on_usb_power;
    logic [7:0]  current_limit_ma;
    logic [15:0] watchdog_reload_ms;
    logic [15:0] wakeup_alarm_s;
    logic        battery_stay_on;
    logic        led_flash_on_cmd;
  } result_t;

endpackage

@@ hw/rtl/bprs_if.sv @@
interface bprs_in_if;
  logic        valid;
  logic        ready;
  logic        key_left;
  logic        key_right;
  logic        cmd_valid;
  logic [3:0]  cmd;
  logic [15:0] parameter_req;
  logic [15:0] input_voltage_mv;
  logic [15:0] battery_voltage_mv;
  logic        charging_active;

  modport source (
    output valid, key_left, key_right, cmd_valid, cmd, parameter_req,
           input_voltage_mv, battery_voltage_mv, charging_active,
    input  ready
  );
  modport sink (
    input  valid, key_left, key_right, cmd_valid, cmd, parameter_req,
           input_voltage_mv, battery_voltage_mv, charging_active,
    output ready
  );
endinterface

interface bprs_out_if;
  logic        valid;
  logic        ready;
  logic        arm_reset;
  logic        boot_normal;
  logic        led_on;
  logic        spi_enabled;
  logic        power_down;
  logic        full_charge_pulse;
  logic        on_usb_power;
  logic [7:0]  current_limit_ma;
  logic [15:0] watchdog_reload_ms;
  logic [15:0] wakeup_alarm_s;
  logic        battery_stay_on;
  logic        led_flash_on_cmd;

  modport source (
    output valid, arm_reset, boot_normal, led_on, spi_enabled, power_down,
           full_charge_pulse, on_usb_power, current_limit_ma,
           watchdog_reload_ms, wakeup_alarm_s, battery_stay_on,
           led_flash_on_cmd,
    input  ready
  );
  modport sink (
    input  valid, arm_reset, boot_normal, led_on, spi_enabled, power_down,
           full_charge_pulse, on_usb_power, current_limit_ma,
           watchdog_reload_ms, wakeup_alarm_s, battery_stay_on,
           led_flash_on_cmd,
    output ready
  );
endinterface

interface bprs_cfg_if;
  import bprs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bprs_cfg.sv @@
module bprs_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_valid_i,
  input  logic [bprs_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [bprs_pkg::CFG_DATA_W-1:0] wr_data_i,
  output bprs_pkg::cfg_t                  cfg_o
);
  import bprs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_USB_ON:    cfg_d.usb_on   = wr_data_i;
        CFG_USB_OFF:   cfg_d.usb_off  = wr_data_i;
        CFG_BAT_CUT:   cfg_d.bat_cut  = wr_data_i;
        CFG_KEY_TICKS: cfg_d.key_def  = wr_data_i[12:0];
        CFG_RST_HOLD:  cfg_d.rst_hold = wr_data_i[7:0];
        CFG_UPS_HOLD:  cfg_d.ups_hold = wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{usb_on:   USB_ON_RST,
                 usb_off:  USB_OFF_RST,
                 bat_cut:  BAT_CUT_RST,
                 key_def:  KEY_TICKS_RST,
                 rst_hold: RST_HOLD_RST,
                 ups_hold: UPS_HOLD_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/bprs_core.sv @@
module bprs_core #(
  parameter int unsigned TICK_MS = bprs_pkg::TICK_MS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bprs_pkg::item_t   item_i,
  input  bprs_pkg::cfg_t    cfg_i,
  output bprs_pkg::result_t res_o
);
  import bprs_pkg::*;

  // ms to ticks by reciprocal multiply, exact for any 16-bit argument
  localparam int unsigned KT_SHIFT = 16 + $clog2(TICK_MS);
  localparam logic [KT_SHIFT:0] KT_MULT =
    (KT_SHIFT+1)'(((64'd1 << KT_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));
  localparam logic [15:0] TICK_STEP = 16'(TICK_MS);

  typedef struct packed {
    logic [15:0] left_cnt;
    logic [15:0] right_cnt;
    logic [7:0]  rst_cnt;
    logic        arm_normal;
    logic        boot_pin;
    logic        rst_line;
    logic        led;
    logic [3:0]  flash_phase;
    logic [2:0]  flashes;
    logic        flash_on_cmd;
    logic [7:0]  spi_cnt;
    logic [15:0] wd_reload;
    logic [15:0] wd_remain;
    logic [7:0]  charge_lim;
    logic        stay_on_bat;
    logic [15:0] alarm_s;
    logic        usb;
    logic [7:0]  ups_cnt;
    logic [12:0] key_ticks;
  } state_t;

  state_t st_q, st_d;

  logic [KT_SHIFT+16:0] kt_prod;
  logic [15:0]          kt_quot;
  logic [12:0]          kt_sat;
  logic                 pd_req;
  logic                 pd_pulse;
  logic                 chg_pulse;

  assign kt_prod = (KT_SHIFT+17)'(item_i.parameter_req) * (KT_SHIFT+17)'(KT_MULT);
  assign kt_quot = kt_prod[KT_SHIFT +: 16];
  assign kt_sat  = (kt_quot > {3'b000, KEY_TICKS_MAX}) ? KEY_TICKS_MAX : kt_quot[12:0];

  always_comb begin
    st_d      = st_q;
    pd_req    = 1'b0;
    pd_pulse  = 1'b0;
    chg_pulse = 1'b0;

    // left key
    if (item_i.key_left) begin
      if (st_d.left_cnt != 16'hFFFF) st_d.left_cnt = st_d.left_cnt + 16'd1;
      if (st_d.left_cnt == {3'b000, st_d.key_ticks}) begin
        if (!item_i.key_right) begin
          st_d.rst_cnt  = cfg_i.rst_hold;
          st_d.boot_pin = st_d.arm_normal;
          st_d.spi_cnt  = SPI_RESET_TICKS;
          st_d.rst_line = 1'b1;
        end else begin
          pd_req = 1'b1;
        end
      end
      if (st_d.left_cnt >= {3'b000, st_d.key_ticks}) st_d.flashes = 3'd1;
    end else begin
      st_d.left_cnt = '0;
      if (st_d.rst_cnt != 8'd0) begin
        st_d.rst_cnt = st_d.rst_cnt - 8'd1;
        if (st_d.rst_cnt == 8'd0) begin
          st_d.key_ticks = cfg_i.key_def;
          st_d.rst_line  = 1'b0;
          st_d.led       = 1'b0;
        end
      end
    end

    // right key alone
    if (item_i.key_right && !item_i.key_left) begin
      if (st_d.right_cnt != 16'hFFFF) st_d.right_cnt = st_d.right_cnt + 16'd1;
      if (st_d.right_cnt == {3'b000, st_d.key_ticks}) begin
        st_d.arm_normal = ~st_d.arm_normal;
        st_d.boot_pin   = st_d.arm_normal;
        st_d.flashes    = st_d.arm_normal ? 3'd2 : 3'd4;
      end
    end else begin
      st_d.right_cnt = '0;
    end

    if (st_d.spi_cnt != 8'd0) st_d.spi_cnt = st_d.spi_cnt - 8'd1;

    // host command
    if (st_d.spi_cnt == 8'd0 && item_i.cmd_valid) begin
      if (st_d.flash_on_cmd) st_d.flashes = 3'd2;
      case (cmd_e'(item_i.cmd))
        CMD_RESTART: begin
          if (item_i.parameter_req == REBOOT_KEEP || item_i.parameter_req == REBOOT_USER ||
              item_i.parameter_req == REBOOT_BOOTLDR) begin
            if (item_i.parameter_req == REBOOT_USER)    st_d.boot_pin = 1'b1;
            if (item_i.parameter_req == REBOOT_BOOTLDR) st_d.boot_pin = 1'b0;
            st_d.rst_line = 1'b1;
            st_d.rst_cnt  = cfg_i.rst_hold;
          end
        end
        CMD_LED:    st_d.flash_on_cmd = item_i.parameter_req[0];
        CMD_WDCTRL: begin
          st_d.wd_reload = item_i.parameter_req;
          st_d.wd_remain = item_i.parameter_req;
        end
        CMD_WDKICK: if (item_i.parameter_req == WD_KICK_KEY) st_d.wd_remain = st_d.wd_reload;
        CMD_CURMAX: if (item_i.parameter_req <= CUR_MAX_MA) begin
          st_d.charge_lim = item_i.parameter_req[7:0];
        end
        CMD_CHARGE: if (item_i.parameter_req == 16'd0) chg_pulse = 1'b1;
        CMD_MODE:   if (item_i.parameter_req < 16'd2) begin
          st_d.stay_on_bat = item_i.parameter_req[0];
        end
        CMD_WAKE_ALARM: st_d.alarm_s = item_i.parameter_req;
        CMD_OFF:    pd_req = 1'b1;
        CMD_KEYTIME: begin
          if (item_i.parameter_req >= KEYTIME_MIN_MS &&
              item_i.parameter_req <= KEYTIME_MAX_MS) begin
            st_d.key_ticks = kt_sat;
          end
        end
        default: ;
      endcase
    end

    // host watchdog
    if (st_d.wd_remain != 16'd0) begin
      if (st_d.wd_remain > TICK_STEP) begin
        st_d.wd_remain = st_d.wd_remain - TICK_STEP;
      end else begin
        st_d.wd_remain = '0;
        st_d.rst_line  = 1'b1;
        st_d.rst_cnt   = cfg_i.rst_hold;
      end
    end

    // LED flash sequence
    if (st_d.flashes != 3'd0) begin
      if (st_d.flash_phase == 4'd0) st_d.led = st_d.flashes[0] ^ item_i.charging_active;
      st_d.flash_phase = st_d.flash_phase + 4'd1;
      if (st_d.flash_phase >= FLASH_PERIOD) begin
        st_d.flashes     = st_d.flashes - 3'd1;
        st_d.flash_phase = '0;
      end
    end else begin
      st_d.led = item_i.charging_active;
    end

    // supply tracking with hysteresis
    if (item_i.input_voltage_mv >= cfg_i.usb_on) st_d.usb = 1'b1;
    if (item_i.input_voltage_mv <= cfg_i.usb_off) begin
      if (st_d.usb && !st_d.stay_on_bat) st_d.ups_cnt = cfg_i.ups_hold;
      st_d.usb = 1'b0;
      if (st_d.ups_cnt != 8'd0) begin
        st_d.ups_cnt = st_d.ups_cnt - 8'd1;
        if (st_d.ups_cnt == 8'd0) pd_req = 1'b1;
      end
    end
    if (!st_d.usb && item_i.battery_voltage_mv != 16'd0 &&
        item_i.battery_voltage_mv <= cfg_i.bat_cut) begin
      pd_req = 1'b1;
    end

    if (pd_req && !st_d.usb) begin
      pd_pulse       = 1'b1;
      st_d.key_ticks = cfg_i.key_def;
      st_d.spi_cnt   = SPI_WAKE_TICKS;
    end
  end

  always_comb begin
    res_o.arm_reset          = st_d.rst_line;
    res_o.boot_normal        = st_d.boot_pin;
    res_o.led_on             = st_d.led;
    res_o.spi_enabled        = (st_d.spi_cnt == 8'd0);
    res_o.power_down         = pd_pulse;
    res_o.full_charge_pulse  = chg_pulse;
    res_o.on_usb_power       = st_d.usb;
    res_o.current_limit_ma   = st_d.charge_lim;
    res_o.watchdog_reload_ms = st_d.wd_reload;
    res_o.wakeup_alarm_s     = st_d.alarm_s;
    res_o.battery_stay_on    = st_d.stay_on_bat;
    res_o.led_flash_on_cmd   = st_d.flash_on_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{arm_normal:   1'b1,
                boot_pin:     1'b1,
                flash_on_cmd: 1'b1,
                charge_lim:   CHARGE_LIM_RST,
                usb:          1'b1,
                key_ticks:    KEY_TICKS_RST,
                default:      '0};
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

@@ hw/rtl/board_power_reset_supervisor_top.sv @@
// An accepted item passes through the input reg and then the result reg before its result shows valid.
// Throughput: one item per cycle while results are taken; the state update sets the pace.
// The input stalls only when the result reg holds an item not taken and the input reg is full.
// Reset (rst_ni low, async) clears all supervisor state and the config registers to
// their documented defaults; no clearing pass is needed.
module board_power_reset_supervisor_top #(
  parameter int unsigned TICK_MS = bprs_pkg::TICK_MS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bprs_in_if.sink    in_i,
  bprs_out_if.source out_o,
  bprs_cfg_if.sink   cfg_i
);
  import bprs_pkg::*;

  item_t   item_q;
  result_t res_d, res_q;
  cfg_t    cfg;
  logic    in_vld_q;
  logic    out_vld_q;
  logic    advance;
  logic    in_ready;

  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready = !in_vld_q || advance;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  bprs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_idx_i   (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  bprs_core #(
    .TICK_MS (TICK_MS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      item_q.key_left           <= in_i.key_left;
      item_q.key_right          <= in_i.key_right;
      item_q.cmd_valid          <= in_i.cmd_valid;
      item_q.cmd                <= in_i.cmd;
      item_q.parameter_req      <= in_i.parameter_req;
      item_q.input_voltage_mv   <= in_i.input_voltage_mv;
      item_q.battery_voltage_mv <= in_i.battery_voltage_mv;
      item_q.charging_active    <= in_i.charging_active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.arm_reset          = res_q.arm_reset;
  assign out_o.boot_normal        = res_q.boot_normal;
  assign out_o.led_on             = res_q.led_on;
  assign out_o.spi_enabled        = res_q.spi_enabled;
  assign out_o.power_down         = res_q.power_down;
  assign out_o.full_charge_pulse  = res_q.full_charge_pulse;
  assign out_o.on_usb_power       = res_q.on_usb_power;
  assign out_o.current_limit_ma   = res_q.current_limit_ma;
  assign out_o.watchdog_reload_ms = res_q.watchdog_reload_ms;
  assign out_o.wakeup_alarm_s     = res_q.wakeup_alarm_s;
  assign out_o.battery_stay_on    = res_q.battery_stay_on;
  assign out_o.led_flash_on_cmd   = res_q.led_flash_on_cmd;

endmodule

@@ hw/rtl/bprs_checker.sv @@
`include "board_power_reset_supervisor_top_assert.svh"

module bprs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       power_down,
  input logic       on_usb_power,
  input logic       spi_enabled,
  input logic [7:0] current_limit_ma
);

  `BPRS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BPRS_ASSERT(a_in_free, !out_valid |-> in_ready, "input stalled with empty output")
  `BPRS_ASSERT(a_pd_batt, out_valid && power_down |-> !on_usb_power, "power down while on USB")
  `BPRS_ASSERT(a_pd_spi, out_valid && power_down |-> !spi_enabled, "host port live at power down")
  `BPRS_ASSERT(a_cur_lim, out_valid |-> current_limit_ma <= 8'd200, "current limit out of range")

endmodule

bind board_power_reset_supervisor_top bprs_checker u_bprs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready         (in_i.ready),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .power_down       (out_o.power_down),
  .on_usb_power     (out_o.on_usb_power),
  .spi_enabled      (out_o.spi_enabled),
  .current_limit_ma (out_o.current_limit_ma)
);
